// File: src/txp_pkg.sv
package txp_pkg;

  // Default width of decoded counts and lengths
  localparam int CountBitsDef = 32;

  // Register reset values
  localparam logic [31:0] MaxInputCountRst   = 32'd100000;
  localparam logic [31:0] MaxOutputCountRst  = 32'd100000;
  localparam logic [31:0] MaxScriptLengthRst = 32'd10000;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_MAX_INPUT  = 2'd0;
  localparam logic [1:0] REG_MAX_OUTPUT = 2'd1;
  localparam logic [1:0] REG_MAX_SCRIPT = 2'd2;

  // Field kind codes
  localparam logic [4:0] KIND_VERSION  = 5'd0;
  localparam logic [4:0] KIND_MARKER   = 5'd1;
  localparam logic [4:0] KIND_FLAG     = 5'd2;
  localparam logic [4:0] KIND_INCOUNT  = 5'd3;
  localparam logic [4:0] KIND_TXID     = 5'd4;
  localparam logic [4:0] KIND_VOUT     = 5'd5;
  localparam logic [4:0] KIND_SIGLEN   = 5'd6;
  localparam logic [4:0] KIND_SIG      = 5'd7;
  localparam logic [4:0] KIND_SEQ      = 5'd8;
  localparam logic [4:0] KIND_OUTCOUNT = 5'd9;
  localparam logic [4:0] KIND_VALUE    = 5'd10;
  localparam logic [4:0] KIND_PKLEN    = 5'd11;
  localparam logic [4:0] KIND_PK       = 5'd12;
  localparam logic [4:0] KIND_WCOUNT   = 5'd13;
  localparam logic [4:0] KIND_WLEN     = 5'd14;
  localparam logic [4:0] KIND_WDATA    = 5'd15;
  localparam logic [4:0] KIND_LOCK     = 5'd16;
  localparam logic [4:0] KIND_NONE     = 5'd17;

  // Parse status codes
  localparam logic [2:0] ST_PARSING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [16:0] {
    PH_VERSION  = 17'h00001,
    PH_AFTERVER = 17'h00002,
    PH_FLAG     = 17'h00004,
    PH_INCOUNT  = 17'h00008,
    PH_TXID     = 17'h00010,
    PH_VOUT     = 17'h00020,
    PH_SIGLEN   = 17'h00040,
    PH_SIG      = 17'h00080,
    PH_SEQ      = 17'h00100,
    PH_OUTCOUNT = 17'h00200,
    PH_VALUE    = 17'h00400,
    PH_PKLEN    = 17'h00800,
    PH_PK       = 17'h01000,
    PH_WCOUNT   = 17'h02000,
    PH_WLEN     = 17'h04000,
    PH_WDATA    = 17'h08000,
    PH_LOCK     = 17'h10000
  } txp_phase_e;

  typedef struct packed {
    logic [31:0] max_input_count;
    logic [31:0] max_output_count;
    logic [31:0] max_script_length;
  } txp_cfg_t;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [31:0] field_offset;
    logic [7:0]  byte_value;
    logic [31:0] input_number;
    logic [31:0] output_number;
    logic [2:0]  parse_status;
    logic        segwit_seen;
    logic        is_coinbase;
    logic [31:0] consumed_count;
    logic [33:0] tx_weight_units;
    logic [31:0] virtual_size;
  } txp_result_t;

  function automatic logic [4:0] phase_kind(txp_phase_e ph);
    logic [4:0] k;
    unique case (ph)
      PH_VERSION:  k = KIND_VERSION;
      PH_AFTERVER: k = KIND_MARKER;
      PH_FLAG:     k = KIND_FLAG;
      PH_INCOUNT:  k = KIND_INCOUNT;
      PH_TXID:     k = KIND_TXID;
      PH_VOUT:     k = KIND_VOUT;
      PH_SIGLEN:   k = KIND_SIGLEN;
      PH_SIG:      k = KIND_SIG;
      PH_SEQ:      k = KIND_SEQ;
      PH_OUTCOUNT: k = KIND_OUTCOUNT;
      PH_VALUE:    k = KIND_VALUE;
      PH_PKLEN:    k = KIND_PKLEN;
      PH_PK:       k = KIND_PK;
      PH_WCOUNT:   k = KIND_WCOUNT;
      PH_WLEN:     k = KIND_WLEN;
      PH_WDATA:    k = KIND_WDATA;
      PH_LOCK:     k = KIND_LOCK;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Canonical compact-size encoding length of a value
  function automatic logic [3:0] canon_size(logic [63:0] v);
    logic [3:0] s;
    if (v < 64'd253) s = 4'd1;
    else if (v <= 64'h0000_0000_0000_ffff) s = 4'd3;
    else if (v <= 64'h0000_0000_ffff_ffff) s = 4'd5;
    else s = 4'd9;
    return s;
  endfunction

endpackage

// File: src/txp_in_if.sv
interface txp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/txp_out_if.sv
interface txp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_kind;
  logic [31:0] field_offset;
  logic [7:0]  byte_value;
  logic [31:0] input_number;
  logic [31:0] output_number;
  logic [2:0]  parse_status;
  logic        segwit_seen;
  logic        is_coinbase;
  logic [31:0] consumed_count;
  logic [33:0] tx_weight_units;
  logic [31:0] virtual_size;

  modport source (
    output valid, input ready,
    output field_kind, output field_offset, output byte_value, output input_number,
    output output_number, output parse_status, output segwit_seen, output is_coinbase,
    output consumed_count, output tx_weight_units, output virtual_size
  );
  modport sink (
    input valid, output ready,
    input field_kind, input field_offset, input byte_value, input input_number,
    input output_number, input parse_status, input segwit_seen, input is_coinbase,
    input consumed_count, input tx_weight_units, input virtual_size
  );
endinterface

// File: src/txp_cfg.sv
module txp_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output txp_pkg::txp_cfg_t cfg_o
);
  import txp_pkg::*;

  txp_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register write, index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_input_count   <= MaxInputCountRst;
      cfg_q.max_output_count  <= MaxOutputCountRst;
      cfg_q.max_script_length <= MaxScriptLengthRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_INPUT:  cfg_q.max_input_count   <= pwdata;
        REG_MAX_OUTPUT: cfg_q.max_output_count  <= pwdata;
        REG_MAX_SCRIPT: cfg_q.max_script_length <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_MAX_INPUT:  prdata = cfg_q.max_input_count;
      REG_MAX_OUTPUT: prdata = cfg_q.max_output_count;
      REG_MAX_SCRIPT: prdata = cfg_q.max_script_length;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// File: src/txp_core.sv
module txp_core #(
  parameter int COUNT_BITS = txp_pkg::CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  txp_pkg::txp_cfg_t    cfg_i,
  output txp_pkg::txp_result_t res_o
);
  import txp_pkg::*;

  localparam int CW = COUNT_BITS;

  txp_phase_e    phase_q, phase_d, ph;
  logic [CW-1:0] fc_q, fc_d;
  logic [63:0]   acc_q, acc_d;
  logic [3:0]    vleft_q, vleft_d;
  logic [CW-1:0] items_q, items_d;
  logic [CW-1:0] witems_q, witems_d;
  logic [CW-1:0] intotal_q, intotal_d;
  logic [CW-1:0] cidx_q, cidx_d;
  logic          segwit_q, segwit_d;
  logic          anyw_q, anyw_d;
  logic          nullok_q, nullok_d;
  logic          fin_q, fin_d;
  logic [31:0]   bcount_q, bcount_d;
  logic [31:0]   wb_q, wb_d;
  logic [31:0]   base_q, base_d;

  // compact-size byte decode
  logic [64:0]   fc_w;
  logic [2:0]    vsh;
  logic [63:0]   vacc;
  logic [CW-1:0] vfc;
  logic [3:0]    vleft_n;
  logic          vdone;
  logic          too_wide;
  logic [31:0]   csz;

  logic [2:0]    verdict;
  logic          do_next_out, do_after_out, do_next_item, do_next_stack;
  logic [63:0]   off64, idx64;
  logic [33:0]   weight;
  logic [34:0]   weight_p3;

  assign fc_w  = 65'(fc_q) + 65'd1;
  assign vsh   = fc_q[2:0] - 3'd1;
  assign off64 = 64'(fc_q);
  assign idx64 = 64'(cidx_q);

  always_comb begin
    if (fc_q == '0) begin
      vfc = CW'(1);
      if (data_byte_i < 8'hfd) begin
        vacc    = 64'(data_byte_i);
        vleft_n = 4'd0;
        vdone   = 1'b1;
      end else begin
        vacc    = 64'd0;
        vleft_n = (data_byte_i == 8'hfd) ? 4'd2 : (data_byte_i == 8'hfe) ? 4'd4 : 4'd8;
        vdone   = 1'b0;
      end
    end else begin
      vfc     = fc_w[CW-1:0];
      vacc    = acc_q | (64'(data_byte_i) << {vsh, 3'b000});
      vleft_n = (vleft_q != 4'd0) ? vleft_q - 4'd1 : 4'd0;
      vdone   = (vleft_n == 4'd0);
    end
  end

  assign too_wide = (vacc >> CW) != 64'd0;
  assign csz      = 32'(canon_size(vacc));

  // Next state and result for one beat
  always_comb begin
    phase_d   = phase_q;
    fc_d      = fc_q;
    acc_d     = acc_q;
    vleft_d   = vleft_q;
    items_d   = items_q;
    witems_d  = witems_q;
    intotal_d = intotal_q;
    cidx_d    = cidx_q;
    segwit_d  = segwit_q;
    anyw_d    = anyw_q;
    nullok_d  = nullok_q;
    fin_d     = fin_q;
    bcount_d  = bcount_q;
    wb_d      = wb_q;
    base_d    = base_q;
    verdict   = ST_PARSING;
    do_next_out   = 1'b0;
    do_after_out  = 1'b0;
    do_next_item  = 1'b0;
    do_next_stack = 1'b0;
    weight    = 34'd0;
    weight_p3 = 35'd0;
    ph = (phase_q == PH_AFTERVER && data_byte_i != 8'h00) ? PH_INCOUNT : phase_q;

    res_o = '0;
    res_o.byte_value = data_byte_i;

    if (step_i && fin_q) begin
      res_o.field_kind   = KIND_NONE;
      res_o.parse_status = ST_IGNORED;
    end else if (step_i) begin
      bcount_d = bcount_q + 32'd1;
      if (ph == PH_INCOUNT) phase_d = PH_INCOUNT;

      unique case (ph)
        PH_VERSION: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= 65'd4) begin phase_d = PH_AFTERVER; fc_d = '0; end
        end
        PH_AFTERVER: begin
          if (last_byte_i) verdict = ST_INVALID;
          else begin phase_d = PH_FLAG; fc_d = '0; end
        end
        PH_FLAG: begin
          if (data_byte_i == 8'h01) begin
            segwit_d = 1'b1;
            phase_d  = PH_INCOUNT;
            fc_d     = '0;
          end else verdict = ST_INVALID;
        end
        PH_TXID: begin
          base_d = base_q + 32'd1;
          if (cidx_q == '0 && data_byte_i != 8'h00) nullok_d = 1'b0;
          fc_d = fc_w[CW-1:0];
          if (fc_w >= 65'd32) begin phase_d = PH_VOUT; fc_d = '0; end
        end
        PH_VOUT: begin
          base_d = base_q + 32'd1;
          if (cidx_q == '0 && data_byte_i != 8'hff) nullok_d = 1'b0;
          fc_d = fc_w[CW-1:0];
          if (fc_w >= 65'd4) begin phase_d = PH_SIGLEN; fc_d = '0; end
        end
        PH_SIG: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= {1'b0, acc_q}) begin phase_d = PH_SEQ; fc_d = '0; end
        end
        PH_SEQ: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= 65'd4) begin
            cidx_d  = cidx_q + CW'(1);
            items_d = items_q - CW'(1);
            fc_d    = '0;
            if (items_q == CW'(1)) begin cidx_d = '0; phase_d = PH_OUTCOUNT; end
            else phase_d = PH_TXID;
          end
        end
        PH_VALUE: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= 65'd8) begin phase_d = PH_PKLEN; fc_d = '0; end
        end
        PH_PK: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= {1'b0, acc_q}) do_next_out = 1'b1;
        end
        PH_WDATA: begin
          wb_d = wb_q + 32'd1;
          fc_d = fc_w[CW-1:0];
          if (fc_w >= {1'b0, acc_q}) do_next_item = 1'b1;
        end
        PH_LOCK: begin
          base_d = base_q + 32'd1;
          fc_d   = fc_w[CW-1:0];
          if (fc_w >= 65'd4) verdict = ST_DONE;
        end
        PH_INCOUNT, PH_SIGLEN, PH_OUTCOUNT, PH_PKLEN, PH_WCOUNT, PH_WLEN: begin
          fc_d    = vfc;
          acc_d   = vacc;
          vleft_d = vleft_n;
          if (vdone) begin
            if (ph == PH_WCOUNT || ph == PH_WLEN) wb_d = wb_q + csz;
            else base_d = base_q + csz;
            if (too_wide) verdict = ST_INVALID;
            else begin
              unique case (ph)
                PH_INCOUNT: begin
                  if (vacc > 64'(cfg_i.max_input_count) || (!segwit_q && vacc == 64'd0))
                    verdict = ST_INVALID;
                  else begin
                    intotal_d = vacc[CW-1:0];
                    items_d   = vacc[CW-1:0];
                    cidx_d    = '0;
                    fc_d      = '0;
                    phase_d   = (vacc == 64'd0) ? PH_OUTCOUNT : PH_TXID;
                  end
                end
                PH_SIGLEN, PH_PKLEN: begin
                  if (vacc > 64'(cfg_i.max_script_length)) verdict = ST_INVALID;
                  else if (vacc == 64'd0) begin
                    if (ph == PH_SIGLEN) begin phase_d = PH_SEQ; fc_d = '0; end
                    else do_next_out = 1'b1;
                  end else begin
                    phase_d = (ph == PH_SIGLEN) ? PH_SIG : PH_PK;
                    fc_d    = '0;
                  end
                end
                PH_OUTCOUNT: begin
                  if (vacc > 64'(cfg_i.max_output_count)) verdict = ST_INVALID;
                  else begin
                    items_d = vacc[CW-1:0];
                    cidx_d  = '0;
                    if (vacc == 64'd0) do_after_out = 1'b1;
                    else begin phase_d = PH_VALUE; fc_d = '0; end
                  end
                end
                PH_WCOUNT: begin
                  if (vacc == 64'd0) do_next_stack = 1'b1;
                  else begin
                    anyw_d   = 1'b1;
                    witems_d = vacc[CW-1:0];
                    phase_d  = PH_WLEN;
                    fc_d     = '0;
                  end
                end
                default: begin
                  if (vacc == 64'd0) do_next_item = 1'b1;
                  else begin phase_d = PH_WDATA; fc_d = '0; end
                end
              endcase
            end
          end
        end
        default: ;
      endcase

      // Shared item and stack advance
      if (do_next_out) begin
        cidx_d  = cidx_q + CW'(1);
        items_d = items_q - CW'(1);
        if (items_q == CW'(1)) do_after_out = 1'b1;
        else begin phase_d = PH_VALUE; fc_d = '0; end
      end
      if (do_after_out) begin
        cidx_d = '0;
        fc_d   = '0;
        if (segwit_q && intotal_q != '0) begin
          items_d = intotal_q;
          phase_d = PH_WCOUNT;
        end else phase_d = PH_LOCK;
      end
      if (do_next_item) begin
        witems_d = witems_q - CW'(1);
        if (witems_q == CW'(1)) do_next_stack = 1'b1;
        else begin phase_d = PH_WLEN; fc_d = '0; end
      end
      if (do_next_stack) begin
        cidx_d  = cidx_q + CW'(1);
        items_d = items_q - CW'(1);
        fc_d    = '0;
        phase_d = (items_q == CW'(1)) ? PH_LOCK : PH_WCOUNT;
      end

      // Result fields
      res_o.field_kind   = phase_kind(ph);
      res_o.field_offset = off64[31:0];
      if (ph == PH_TXID || ph == PH_VOUT || ph == PH_SIGLEN || ph == PH_SIG ||
          ph == PH_SEQ || ph == PH_WCOUNT || ph == PH_WLEN || ph == PH_WDATA)
        res_o.input_number = idx64[31:0];
      if (ph == PH_VALUE || ph == PH_PKLEN || ph == PH_PK)
        res_o.output_number = idx64[31:0];
      res_o.segwit_seen = segwit_d;

      // Sizes on the closing byte: weight = 4 * base + witness part
      if (verdict == ST_DONE) begin
        weight    = {base_d, 2'b00} + ((segwit_q && anyw_q) ? 34'(wb_q) + 34'd2 : 34'd0);
        weight_p3 = 35'(weight) + 35'd3;
        res_o.is_coinbase     = (intotal_q == CW'(1)) && nullok_q;
        res_o.consumed_count  = bcount_d;
        res_o.tx_weight_units = weight;
        res_o.virtual_size    = weight_p3[33:2];
      end

      res_o.parse_status = (verdict != ST_PARSING) ? verdict :
                           (last_byte_i ? ST_TRUNC : ST_PARSING);
      if (!last_byte_i && verdict != ST_PARSING) fin_d = 1'b1;
    end

    // Buffer end rearms for the next transaction
    if (step_i && last_byte_i) begin
      phase_d   = PH_VERSION;
      fc_d      = '0;
      acc_d     = 64'd0;
      vleft_d   = 4'd0;
      items_d   = '0;
      witems_d  = '0;
      intotal_d = '0;
      cidx_d    = '0;
      segwit_d  = 1'b0;
      anyw_d    = 1'b0;
      nullok_d  = 1'b1;
      fin_d     = 1'b0;
      bcount_d  = 32'd0;
      wb_d      = 32'd0;
      base_d    = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VERSION;
      fc_q      <= '0;
      acc_q     <= 64'd0;
      vleft_q   <= 4'd0;
      items_q   <= '0;
      witems_q  <= '0;
      intotal_q <= '0;
      cidx_q    <= '0;
      segwit_q  <= 1'b0;
      anyw_q    <= 1'b0;
      nullok_q  <= 1'b1;
      fin_q     <= 1'b0;
      bcount_q  <= 32'd0;
      wb_q      <= 32'd0;
      base_q    <= 32'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fc_q      <= fc_d;
      acc_q     <= acc_d;
      vleft_q   <= vleft_d;
      items_q   <= items_d;
      witems_q  <= witems_d;
      intotal_q <= intotal_d;
      cidx_q    <= cidx_d;
      segwit_q  <= segwit_d;
      anyw_q    <= anyw_d;
      nullok_q  <= nullok_d;
      fin_q     <= fin_d;
      bcount_q  <= bcount_d;
      wb_q      <= wb_d;
      base_q    <= base_d;
    end
  end
endmodule

// File: src/tx_wire_stream_parser.sv
// Byte-serial transaction parser.
// in_if carries one buffer byte per beat plus last_byte marking the buffer end.
// out_if returns one beat per input byte: field kind, offset in the field,
// the byte itself, input/output index and parse status; the closing locktime
// byte also carries consumed bytes, weight, virtual size and the coinbase flag.
// The result of a byte is on out_if in the cycle after its input beat.
// Throughput: one byte per cycle; the phase update is a single pass of logic
// between the parse state registers and the result register.
// The result register decouples the sides: a byte is taken while the previous
// result is being accepted. When out_if stalls, in_if.ready drops and the held
// result stays until taken.
// The APB port holds the input count, output count and script length limits
// at byte addresses 0x0, 0x4 and 0x8; write them only while the block is idle.
// Reset (rst_ni low) returns the parser to the version field, empties the
// result register and restores the limits. After done or an error, bytes are
// ignored until the one carrying last_byte, which rearms the parser.
module tx_wire_stream_parser #(
  parameter int COUNT_BITS = txp_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  txp_in_if.sink      in_if,
  txp_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import txp_pkg::*;

  txp_cfg_t    cfg;
  txp_result_t res;
  txp_result_t result_q;
  logic        out_valid_q;
  logic        step;

  txp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take a beat when the result register is free or draining
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  txp_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_if.data_byte),
    .last_byte_i (in_if.last_byte),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) result_q <= res;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.field_kind      = result_q.field_kind;
  assign out_if.field_offset    = result_q.field_offset;
  assign out_if.byte_value      = result_q.byte_value;
  assign out_if.input_number    = result_q.input_number;
  assign out_if.output_number   = result_q.output_number;
  assign out_if.parse_status    = result_q.parse_status;
  assign out_if.segwit_seen     = result_q.segwit_seen;
  assign out_if.is_coinbase     = result_q.is_coinbase;
  assign out_if.consumed_count  = result_q.consumed_count;
  assign out_if.tx_weight_units = result_q.tx_weight_units;
  assign out_if.virtual_size    = result_q.virtual_size;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while result stalled");

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_done_on_locktime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.parse_status == ST_DONE) |-> result_q.field_kind == KIND_LOCK)
    else $error("done reported outside locktime");

  a_ignored_is_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.parse_status == ST_IGNORED) |->
      (result_q.field_kind == KIND_NONE && result_q.consumed_count == 32'd0))
    else $error("ignored beat carries field data");
`endif
endmodule

// File: bench/tb_tx_wire_stream_parser.sv
module tb_tx_wire_stream_parser;
  import txp_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  txp_in_if  in_bus ();
  txp_out_if out_bus ();

  tx_wire_stream_parser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shared bench state
  txp_result_t    expected_beats[$];
  logic [7:0]     tx_q[$];
  int             fail_count = 0;
  int             bytes_sent = 0;
  int             stall_req = 0;
  bit             send_nogap = 1'b0;
  bit             recv_nogap = 1'b0;

  // Parser shadow state and limits
  logic [31:0] lim_in, lim_out, lim_script;
  logic [4:0]  ph;
  logic [63:0] fcnt, vacc, ileft, wleft, itotal, cidx;
  int unsigned vleft;
  bit          segw, anyw, nullok, fin;
  logic [31:0] bcnt, wbcnt, bsize;
  int          verd;

  function automatic void rearm();
    ph = KIND_VERSION; fcnt = 0; vacc = 0; vleft = 0; ileft = 0; wleft = 0;
    itotal = 0; cidx = 0; segw = 0; anyw = 0; nullok = 1; bcnt = 0; wbcnt = 0;
    bsize = 0; fin = 0;
  endfunction

  function automatic void enter(logic [4:0] p);
    ph = p;
    fcnt = 0;
  endfunction

  function automatic logic [31:0] cs_len(logic [63:0] v);
    if (v < 64'd253) return 1;
    if (v <= 64'hffff) return 3;
    if (v <= 64'hffff_ffff) return 5;
    return 9;
  endfunction

  function automatic bit fixed_done(logic [63:0] len);
    fcnt++;
    return fcnt >= len;
  endfunction

  // Feeds one compact-size byte; 1 when the value is complete
  function automatic bit cs_feed(logic [7:0] b);
    if (fcnt == 0) begin
      fcnt = 1;
      if (b < 8'hfd) begin
        vacc = 64'(b);
        return 1;
      end
      vleft = (b == 8'hfd) ? 2 : (b == 8'hfe) ? 4 : 8;
      vacc = 0;
      return 0;
    end
    vacc |= 64'(b) << (8 * ((fcnt - 1) & 7));
    fcnt++;
    if (vleft > 0) vleft--;
    return vleft == 0;
  endfunction

  function automatic void after_outputs();
    cidx = 0;
    if (segw && itotal > 0) begin
      ileft = itotal;
      enter(KIND_WCOUNT);
    end else begin
      enter(KIND_LOCK);
    end
  endfunction

  function automatic void next_input();
    cidx++; ileft--;
    if (ileft == 0) begin
      cidx = 0;
      enter(KIND_OUTCOUNT);
    end else enter(KIND_TXID);
  endfunction

  function automatic void next_output();
    cidx++; ileft--;
    if (ileft == 0) after_outputs();
    else enter(KIND_VALUE);
  endfunction

  function automatic void next_stack();
    cidx++; ileft--;
    if (ileft == 0) enter(KIND_LOCK);
    else enter(KIND_WCOUNT);
  endfunction

  function automatic void next_witem();
    wleft--;
    if (wleft == 0) next_stack();
    else enter(KIND_WLEN);
  endfunction

  function automatic void cs_done(logic [4:0] p);
    logic [63:0] v;
    v = vacc;
    if (p == KIND_WCOUNT || p == KIND_WLEN) wbcnt += cs_len(v);
    else bsize += cs_len(v);
    if (v > 64'hffff_ffff) begin
      verd = 3;
      return;
    end
    case (p)
      KIND_INCOUNT: begin
        if (v > 64'(lim_in) || (!segw && v == 0)) begin
          verd = 3;
          return;
        end
        itotal = v; ileft = v; cidx = 0;
        enter(v == 0 ? KIND_OUTCOUNT : KIND_TXID);
      end
      KIND_SIGLEN, KIND_PKLEN: begin
        if (v > 64'(lim_script)) begin
          verd = 3;
          return;
        end
        if (v == 0) begin
          if (p == KIND_SIGLEN) enter(KIND_SEQ);
          else next_output();
        end else begin
          enter(p == KIND_SIGLEN ? KIND_SIG : KIND_PK);
          vacc = v;
        end
      end
      KIND_OUTCOUNT: begin
        if (v > 64'(lim_out)) begin
          verd = 3;
          return;
        end
        ileft = v; cidx = 0;
        if (v == 0) after_outputs();
        else enter(KIND_VALUE);
      end
      KIND_WCOUNT: begin
        if (v == 0) next_stack();
        else begin
          anyw = 1; wleft = v;
          enter(KIND_WLEN);
        end
      end
      default: begin
        if (v == 0) next_witem();
        else begin
          enter(KIND_WDATA);
          vacc = v;
        end
      end
    endcase
  endfunction

  // Expected result beat for one accepted byte
  function automatic txp_result_t parse_byte(logic [7:0] b, bit last);
    txp_result_t r;
    logic [4:0]  kind;
    logic [63:0] off, idx, base, total, w;
    r = '0;
    r.byte_value = b;
    if (fin) begin
      r.field_kind = KIND_NONE;
      r.parse_status = ST_IGNORED;
      if (last) rearm();
      return r;
    end
    bcnt++;
    verd = 0;
    if (ph == KIND_MARKER && b != 0) enter(KIND_INCOUNT);
    kind = ph; off = fcnt; idx = cidx;
    case (ph)
      KIND_VERSION: begin
        bsize++;
        if (fixed_done(4)) enter(KIND_MARKER);
      end
      KIND_MARKER: begin
        if (last) verd = 3;
        else enter(KIND_FLAG);
      end
      KIND_FLAG: begin
        if (b == 8'h01) begin
          segw = 1;
          enter(KIND_INCOUNT);
        end else verd = 3;
      end
      KIND_TXID: begin
        bsize++;
        if (cidx == 0 && b != 8'h00) nullok = 0;
        if (fixed_done(32)) enter(KIND_VOUT);
      end
      KIND_VOUT: begin
        bsize++;
        if (cidx == 0 && b != 8'hff) nullok = 0;
        if (fixed_done(4)) enter(KIND_SIGLEN);
      end
      KIND_SIG: begin
        bsize++;
        if (fixed_done(vacc)) enter(KIND_SEQ);
      end
      KIND_SEQ: begin
        bsize++;
        if (fixed_done(4)) next_input();
      end
      KIND_VALUE: begin
        bsize++;
        if (fixed_done(8)) enter(KIND_PKLEN);
      end
      KIND_PK: begin
        bsize++;
        if (fixed_done(vacc)) next_output();
      end
      KIND_WDATA: begin
        wbcnt++;
        if (fixed_done(vacc)) next_witem();
      end
      KIND_LOCK: begin
        bsize++;
        if (fixed_done(4)) verd = 1;
      end
      default: begin
        if (cs_feed(b)) cs_done(ph);
      end
    endcase
    r.field_kind = kind;
    r.field_offset = off[31:0];
    if ((kind >= KIND_TXID && kind <= KIND_SEQ) || (kind >= KIND_WCOUNT && kind <= KIND_WDATA))
      r.input_number = idx[31:0];
    if (kind >= KIND_VALUE && kind <= KIND_PK) r.output_number = idx[31:0];
    r.segwit_seen = segw;
    if (verd == 1) begin
      base = 64'(bsize);
      total = base;
      if (segw && anyw) total += 2 + 64'(wbcnt);
      w = (3 * base + total) & 64'h3_ffff_ffff;
      r.is_coinbase = (itotal == 1 && nullok);
      r.consumed_count = bcnt;
      r.tx_weight_units = w[33:0];
      r.virtual_size = 32'((w + 3) / 4);
    end
    r.parse_status = (verd != 0) ? 3'(verd) : (last ? ST_TRUNC : ST_PARSING);
    if (last) rearm();
    else if (verd != 0) fin = 1;
    return r;
  endfunction

  // Byte source: random gap, then hold the beat until taken
  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    gap = send_nogap ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_beats.push_back(parse_byte(b, last));
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (tx_q[i]) send_byte(tx_q[i], i == tx_q.size() - 1);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  // Result sink and checker
  initial begin
    txp_result_t e;
    int w;
    out_bus.ready = 1'b0;
    forever begin
      w = (stall_req > 0) ? stall_req : (recv_nogap ? 0 : $urandom_range(0, 13));
      stall_req = 0;
      @(negedge clk_i);
      if (w > 0) begin
        out_bus.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected, byte %0h", out_bus.byte_value);
        fail_count++;
      end else begin
        e = expected_beats.pop_front();
        if (out_bus.field_kind !== e.field_kind) begin
          $error("field_kind exp %0d got %0d", e.field_kind, out_bus.field_kind);
          fail_count++;
        end
        if (out_bus.field_offset !== e.field_offset) begin
          $error("field_offset exp %0d got %0d", e.field_offset, out_bus.field_offset);
          fail_count++;
        end
        if (out_bus.byte_value !== e.byte_value) begin
          $error("byte_value exp %0h got %0h", e.byte_value, out_bus.byte_value);
          fail_count++;
        end
        if (out_bus.input_number !== e.input_number) begin
          $error("input_number exp %0d got %0d", e.input_number, out_bus.input_number);
          fail_count++;
        end
        if (out_bus.output_number !== e.output_number) begin
          $error("output_number exp %0d got %0d", e.output_number, out_bus.output_number);
          fail_count++;
        end
        if (out_bus.parse_status !== e.parse_status) begin
          $error("parse_status exp %0d got %0d", e.parse_status, out_bus.parse_status);
          fail_count++;
        end
        if (out_bus.segwit_seen !== e.segwit_seen) begin
          $error("segwit_seen exp %0b got %0b", e.segwit_seen, out_bus.segwit_seen);
          fail_count++;
        end
        if (out_bus.is_coinbase !== e.is_coinbase) begin
          $error("is_coinbase exp %0b got %0b", e.is_coinbase, out_bus.is_coinbase);
          fail_count++;
        end
        if (out_bus.consumed_count !== e.consumed_count) begin
          $error("consumed_count exp %0d got %0d", e.consumed_count, out_bus.consumed_count);
          fail_count++;
        end
        if (out_bus.tx_weight_units !== e.tx_weight_units) begin
          $error("tx_weight_units exp %0d got %0d", e.tx_weight_units,
                 out_bus.tx_weight_units);
          fail_count++;
        end
        if (out_bus.virtual_size !== e.virtual_size) begin
          $error("virtual_size exp %0d got %0d", e.virtual_size, out_bus.virtual_size);
          fail_count++;
        end
      end
    end
  end

  // Idle: all results back and the result register drained
  task automatic drain();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAX_INPUT:  lim_in = v;
      REG_MAX_OUTPUT: lim_out = v;
      REG_MAX_SCRIPT: lim_script = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_limits(logic [31:0] li, logic [31:0] lo, logic [31:0] ls);
    drain();
    write_limit(REG_MAX_INPUT, li);
    write_limit(REG_MAX_OUTPUT, lo);
    write_limit(REG_MAX_SCRIPT, ls);
  endtask

  // Buffer building
  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) tx_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_rand(int n);
    repeat (n) tx_q.push_back(8'($urandom));
  endfunction

  // Compact size, now and then in a wider form than needed
  function automatic void put_cs(logic [63:0] v);
    int lvl;
    lvl = (v < 253) ? 0 : (v <= 64'hffff) ? 1 : (v <= 64'hffff_ffff) ? 2 : 3;
    if (lvl < 3 && $urandom_range(0, 9) == 0) lvl++;
    case (lvl)
      0: tx_q.push_back(v[7:0]);
      1: begin tx_q.push_back(8'hfd); put_le(v, 2); end
      2: begin tx_q.push_back(8'hfe); put_le(v, 4); end
      default: begin tx_q.push_back(8'hff); put_le(v, 8); end
    endcase
  endfunction

  // wmode: 0 random stacks, 1 all stacks empty
  function automatic void build_tx(bit sw, int nin, int nout, bit cb, int wmode);
    int n, k;
    tx_q.delete();
    put_rand(4);
    if (sw) begin tx_q.push_back(8'h00); tx_q.push_back(8'h01); end
    put_cs(nin);
    for (int i = 0; i < nin; i++) begin
      if (cb) begin repeat (4) put_le(0, 8); put_le(64'hffff_ffff, 4); end
      else put_rand(36);
      n = $urandom_range(0, 4);
      put_cs(n); put_rand(n); put_rand(4);
    end
    put_cs(nout);
    for (int i = 0; i < nout; i++) begin
      put_rand(8);
      n = $urandom_range(0, 4);
      put_cs(n); put_rand(n);
    end
    if (sw) begin
      for (int i = 0; i < nin; i++) begin
        k = (wmode == 1) ? 0 : $urandom_range(0, 2);
        put_cs(k);
        for (int j = 0; j < k; j++) begin
          n = $urandom_range(0, 3);
          put_cs(n); put_rand(n);
        end
      end
    end
    put_rand(4);
  endfunction

  task automatic test_directed();
    // legacy coinbase, clean timing
    send_nogap = 1; recv_nogap = 1;
    build_tx(0, 1, 1, 1, 0); send_buffer();
    send_nogap = 0; recv_nogap = 0;
    // witness form with items, then with all stacks empty
    build_tx(1, 2, 1, 0, 0); send_buffer();
    build_tx(1, 1, 2, 1, 1); send_buffer();
    // witness form, zero inputs and zero outputs
    build_tx(1, 0, 0, 0, 0); send_buffer();
    // legacy with no inputs, count written wide
    tx_q.delete(); put_rand(4); tx_q.push_back(8'hfd); put_le(0, 2); put_rand(3);
    send_buffer();
    // marker followed by a bad flag
    tx_q.delete(); put_rand(4); tx_q.push_back(8'h00); tx_q.push_back(8'h02);
    send_buffer();
    // buffer ends on the marker
    tx_q.delete(); put_rand(4); tx_q.push_back(8'h00); send_buffer();
    // count one above the widest allowed value
    tx_q.delete(); put_rand(4); tx_q.push_back(8'hff); put_le(64'h1_0000_0000, 8);
    send_buffer();
    // truncation in the middle of a txid
    build_tx(0, 1, 1, 0, 0); tx_q = tx_q[0:10]; send_buffer();
    // bytes after a finished transaction
    build_tx(0, 1, 1, 0, 0); put_rand(3); send_buffer();
  endtask

  task automatic test_limits();
    // all limits zero: any nonzero count or script length fails
    set_limits(0, 0, 0);
    build_tx(0, 1, 1, 0, 0); send_buffer();
    build_tx(1, 0, 0, 0, 0); send_buffer();
    tx_q.delete(); put_rand(4); tx_q.push_back(8'h00); tx_q.push_back(8'h01);
    tx_q.push_back(8'h00); tx_q.push_back(8'h01); put_rand(2);
    send_buffer();
    // all limits at maximum: widest counts pass, then truncate
    set_limits(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    tx_q.delete(); put_rand(4); tx_q.push_back(8'hfe); put_le(64'hffff_ffff, 4);
    put_rand(3); send_buffer();
    tx_q.delete(); put_rand(4); tx_q.push_back(8'hff); put_le(64'hffff_ffff, 8);
    put_rand(40); tx_q.push_back(8'hfe); put_le(64'hffff_ffff, 4); put_rand(5);
    send_buffer();
    build_tx(1, 2, 2, 0, 0); send_buffer();
    // unused register index leaves the limits alone
    drain();
    write_limit(RegUnused, 32'd0);
    build_tx(0, 1, 1, 0, 0); send_buffer();
  endtask

  task automatic test_backpressure();
    drain();
    stall_req = 300;
    send_nogap = 1;
    build_tx(1, 2, 2, 0, 0); send_buffer();
    send_nogap = 0;
  endtask

  task automatic test_random();
    int sel, pos;
    bit sw;
    while (bytes_sent < 650) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: set_limits(100000, 100000, 10000);
          1: set_limits($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4));
          2: set_limits(32'hffff_ffff, $urandom, $urandom_range(2, 5));
          default: set_limits($urandom, $urandom, $urandom);
        endcase
      end
      send_nogap = ($urandom_range(0, 3) == 0);
      recv_nogap = ($urandom_range(0, 3) == 0);
      sw = $urandom_range(0, 1);
      build_tx(sw, $urandom_range(sw ? 0 : 1, 2), $urandom_range(0, 2),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 12) ;
      else if (sel < 15) put_rand($urandom_range(1, 4));
      else if (sel < 18) tx_q = tx_q[0:$urandom_range(0, tx_q.size() - 2)];
      else if (sel < 19) begin
        pos = $urandom_range(0, tx_q.size() - 1);
        tx_q[pos] = 8'($urandom);
      end else begin
        tx_q.delete();
        put_rand($urandom_range(1, 8));
      end
      send_buffer();
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    lim_in = MaxInputCountRst;
    lim_out = MaxOutputCountRst;
    lim_script = MaxScriptLengthRst;
    rearm();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    repeat (5) @(posedge clk_i);
    if (expected_beats.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: tx_wire_stream_parser.f
src/txp_pkg.sv
src/txp_in_if.sv
src/txp_out_if.sv
src/txp_cfg.sv
src/txp_core.sv
src/tx_wire_stream_parser.sv
bench/tb_tx_wire_stream_parser.sv
